[sv/vrra_pkg.sv]
// ----------------------------------------------------------------------------
// vrra_pkg
// Shared types and constants for the variable record ring allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package vrra_pkg;

  localparam int unsigned BUFFER_BYTES = 4096;
  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned ADDR_W       = $clog2(BUFFER_BYTES);
  localparam int unsigned POS_W        = ADDR_W + 1;
  localparam int unsigned SIZE_W       = 12;
  localparam int unsigned HDR_W        = SIZE_W + 1;
  localparam int unsigned IN_TDATA_W   = 32;
  localparam int unsigned OUT_TDATA_W  = 32;

  localparam logic [POS_W-1:0] HDR_POS   = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] SLACK_POS = POS_W'(2 * HEADER_BYTES);
  localparam logic [POS_W:0]   END_POS   = (POS_W + 1)'(BUFFER_BYTES);

  typedef enum logic [1:0] {
    OP_RESERVE_PUSH  = 2'd0,
    OP_FINALIZE_PUSH = 2'd1,
    OP_RESERVE_POP   = 2'd2,
    OP_FINALIZE_POP  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_NOTHING  = 3'd2,
    ST_MISMATCH = 3'd3,
    ST_BAD_SIZE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_PUSH_WRAP,
    S_FPUSH,
    S_POP_CHK,
    S_POP_EVAL,
    S_FPOP,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[sv/variable_record_ring_allocator_top.sv]
// ----------------------------------------------------------------------------
// variable_record_ring_allocator_top
// Allocator for a byte ring of variable-size records, headers in one RAM.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on s_axis, one response beat leaves on
// m_axis for every command. Commands are reserve_push, finalize_push,
// reserve_pop and finalize_pop; responses carry status, payload offset and
// record size.
// Steps per command: reserve_push runs S_PUSH, plus S_PUSH_WRAP when it
// wraps behind a stored skip marker; finalize_push reads the header and
// writes it back marked final; finalize_pop reads and checks it; reserve_pop
// loops S_POP_CHK and S_POP_EVAL once more per skip marker it passes; all
// end in S_DONE, which loads the output register. Commands are handled one
// at a time; the next beat is taken in the cycle after the response is
// loaded. The time goes to header RAM reads (registered read port), header
// writes, the step over the buffer end and the output register load.
// A finished response sits in an output register, so the next command is
// taken while the response still waits. If the receiver stalls with a full
// output register, the block finishes the current command and holds.
// Reset clears read and write positions (empty ring) and the handshake
// state; the header RAM is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_record_ring_allocator_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // [1:0] op, [13:2] request_size, [25:14] handle, rest zero
  input  wire logic [vrra_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // [2:0] status, [14:3] payload_offset, [26:15] record_size, rest zero
  output logic [vrra_pkg::OUT_TDATA_W-1:0]         m_axis_tdata_o
);

  localparam int unsigned AW = vrra_pkg::ADDR_W;
  localparam int unsigned PW = vrra_pkg::POS_W;
  localparam int unsigned SW = vrra_pkg::SIZE_W;
  localparam int unsigned HW = vrra_pkg::HDR_W;

  // header RAM
  logic [HW-1:0] hdr_mem [vrra_pkg::BUFFER_BYTES];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [HW-1:0] mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [HW-1:0] mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hdr_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= hdr_mem[mem_raddr];
    end
  end

  vrra_pkg::state_e  state_q, state_d;
  logic [PW-1:0]     rd_pos_q, rd_pos_d;
  logic [PW-1:0]     wr_pos_q, wr_pos_d;
  logic [1:0]        pass_q, pass_d;
  logic [SW-1:0]     size_q;
  logic [SW-1:0]     handle_q;
  vrra_pkg::status_e res_status_q, res_status_d;
  logic [SW-1:0]     res_off_q, res_off_d;
  logic [SW-1:0]     res_size_q, res_size_d;
  logic              out_valid_q, out_valid_d;
  logic [vrra_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic              in_fire;
  vrra_pkg::op_e     in_op;
  logic [SW-1:0]     in_size;
  logic [SW-1:0]     in_handle;
  logic [PW-1:0]     need;
  logic [PW:0]       w_end;
  logic              slot_free;

  assign in_op     = vrra_pkg::op_e'(s_axis_tdata_i[1:0]);
  assign in_size   = s_axis_tdata_i[13:2];
  assign in_handle = s_axis_tdata_i[25:14];

  assign s_axis_tready_o = (state_q == vrra_pkg::S_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign slot_free       = ~out_valid_q | m_axis_tready_i;

  assign need  = PW'(size_q) + vrra_pkg::SLACK_POS;
  assign w_end = {1'b0, wr_pos_q} + {1'b0, need};

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vrra_pkg::S_IDLE;
      rd_pos_q    <= '0;
      wr_pos_q    <= '0;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_pos_q    <= rd_pos_d;
      wr_pos_q    <= wr_pos_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      size_q   <= in_size;
      handle_q <= in_handle;
    end
    res_status_q <= res_status_d;
    res_off_q    <= res_off_d;
    res_size_q   <= res_size_d;
    out_data_q   <= out_data_d;
  end

  always_comb begin
    state_d      = state_q;
    rd_pos_d     = rd_pos_q;
    wr_pos_d     = wr_pos_q;
    pass_d       = pass_q;
    res_status_d = res_status_q;
    res_off_d    = res_off_q;
    res_size_d   = res_size_q;
    out_valid_d  = out_valid_q & ~m_axis_tready_i;
    out_data_d   = out_data_q;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;

    case (state_q)
      vrra_pkg::S_IDLE: begin
        if (in_fire) begin
          pass_d = '0;
          case (in_op)
            vrra_pkg::OP_RESERVE_PUSH: begin
              state_d = vrra_pkg::S_PUSH;
            end
            vrra_pkg::OP_FINALIZE_PUSH: begin
              mem_re    = 1'b1;
              mem_raddr = in_handle - AW'(vrra_pkg::HEADER_BYTES);
              state_d   = vrra_pkg::S_FPUSH;
            end
            vrra_pkg::OP_RESERVE_POP: begin
              state_d = vrra_pkg::S_POP_CHK;
            end
            vrra_pkg::OP_FINALIZE_POP: begin
              mem_re    = 1'b1;
              mem_raddr = rd_pos_q[AW-1:0];
              state_d   = vrra_pkg::S_FPOP;
            end
            default: begin
              state_d = vrra_pkg::S_IDLE;
            end
          endcase
        end
      end

      vrra_pkg::S_PUSH: begin
        res_status_d = vrra_pkg::ST_OK;
        res_off_d    = '0;
        res_size_d   = '0;
        state_d      = vrra_pkg::S_DONE;
        if (size_q == '0) begin
          res_status_d = vrra_pkg::ST_BAD_SIZE;
        end else if (wr_pos_q < rd_pos_q) begin
          if (need >= rd_pos_q - wr_pos_q) begin
            res_status_d = vrra_pkg::ST_NO_SPACE;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = wr_pos_q[AW-1:0];
            mem_wdata = {1'b0, size_q};
            wr_pos_d  = w_end[PW-1:0];
            res_off_d = SW'(wr_pos_q + vrra_pkg::HDR_POS);
          end
        end else if (w_end <= vrra_pkg::END_POS) begin
          mem_we    = 1'b1;
          mem_waddr = wr_pos_q[AW-1:0];
          mem_wdata = {1'b0, size_q};
          wr_pos_d  = w_end[PW-1:0];
          res_off_d = SW'(wr_pos_q + vrra_pkg::HDR_POS);
        end else if (need >= rd_pos_q) begin
          res_status_d = vrra_pkg::ST_NO_SPACE;
        end else if (wr_pos_q[PW-1]) begin
          // buffer end is an implied skip marker
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = {1'b0, size_q};
          wr_pos_d  = need;
          res_off_d = SW'(vrra_pkg::HDR_POS);
        end else begin
          mem_we    = 1'b1;
          mem_waddr = wr_pos_q[AW-1:0];
          mem_wdata = {1'b1, {SW{1'b0}}};
          state_d   = vrra_pkg::S_PUSH_WRAP;
        end
      end

      vrra_pkg::S_PUSH_WRAP: begin
        mem_we       = 1'b1;
        mem_waddr    = '0;
        mem_wdata    = {1'b0, size_q};
        wr_pos_d     = need;
        res_status_d = vrra_pkg::ST_OK;
        res_off_d    = SW'(vrra_pkg::HDR_POS);
        res_size_d   = '0;
        state_d      = vrra_pkg::S_DONE;
      end

      vrra_pkg::S_FPUSH: begin
        res_off_d  = '0;
        res_size_d = '0;
        state_d    = vrra_pkg::S_DONE;
        if (handle_q < SW'(vrra_pkg::HEADER_BYTES)) begin
          res_status_d = vrra_pkg::ST_MISMATCH;
        end else begin
          mem_we       = 1'b1;
          mem_waddr    = handle_q - AW'(vrra_pkg::HEADER_BYTES);
          mem_wdata    = {1'b1, mem_rdata_q[SW-1:0]};
          res_status_d = vrra_pkg::ST_OK;
        end
      end

      vrra_pkg::S_POP_CHK: begin
        if (pass_q == 2'd3 || rd_pos_q == wr_pos_q) begin
          res_status_d = vrra_pkg::ST_NOTHING;
          res_off_d    = '0;
          res_size_d   = '0;
          state_d      = vrra_pkg::S_DONE;
        end else if (rd_pos_q[PW-1]) begin
          rd_pos_d = '0;
          pass_d   = pass_q + 2'd1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_pos_q[AW-1:0];
          state_d   = vrra_pkg::S_POP_EVAL;
        end
      end

      vrra_pkg::S_POP_EVAL: begin
        if (!mem_rdata_q[SW]) begin
          res_status_d = vrra_pkg::ST_NOTHING;
          res_off_d    = '0;
          res_size_d   = '0;
          state_d      = vrra_pkg::S_DONE;
        end else if (mem_rdata_q[SW-1:0] == '0) begin
          rd_pos_d = '0;
          pass_d   = pass_q + 2'd1;
          state_d  = vrra_pkg::S_POP_CHK;
        end else begin
          res_status_d = vrra_pkg::ST_OK;
          res_off_d    = SW'(rd_pos_q + vrra_pkg::HDR_POS);
          res_size_d   = mem_rdata_q[SW-1:0];
          state_d      = vrra_pkg::S_DONE;
        end
      end

      vrra_pkg::S_FPOP: begin
        res_off_d  = '0;
        res_size_d = '0;
        state_d    = vrra_pkg::S_DONE;
        if (rd_pos_q == wr_pos_q || rd_pos_q[PW-1] ||
            {1'b0, handle_q} != rd_pos_q + vrra_pkg::HDR_POS ||
            !mem_rdata_q[SW] || mem_rdata_q[SW-1:0] == '0) begin
          res_status_d = vrra_pkg::ST_MISMATCH;
        end else begin
          res_status_d = vrra_pkg::ST_OK;
          rd_pos_d     = rd_pos_q + vrra_pkg::SLACK_POS + PW'(mem_rdata_q[SW-1:0]);
        end
      end

      vrra_pkg::S_DONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = vrra_pkg::OUT_TDATA_W'({res_size_q, res_off_q, res_status_q});
          state_d     = vrra_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = vrra_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire
